### hdl/assert_macros.svh
// Assertion macros shared by the parallel handshake RTL.
// Depends on nothing; included inside module bodies that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");

`endif

### hdl/pht_pkg.sv
// Types and codes for the parallel handshake link: request and result layouts,
// handshake phases and command codes. Depends on nothing.
`default_nettype none

package pht_pkg;

    localparam int unsigned TDATA_W = 32;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_SEND = 2'd1,
        CMD_RECV = 2'd2,
        CMD_ATN  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_S_RFD    = 3'd1,
        PH_S_DAC_HI = 3'd2,
        PH_S_DAC_LO = 3'd3,
        PH_R_DAV_HI = 3'd4,
        PH_R_DAV_LO = 3'd5,
        PH_WAIT_ATN = 3'd6
    } phase_t;

    // Driven handshake lines, DAV in the lowest bit.
    typedef struct packed {
        logic dac;
        logic rfd;
        logic dav;
    } lines_t;

    // One sampled tick, last field in the lowest bits.
    typedef struct packed {
        logic [7:0]  bus_in;
        logic        partner_atn;
        logic        partner_dac;
        logic        partner_rfd;
        logic        partner_dav;
        logic [15:0] send_word;
        logic        two_bytes;
        logic [1:0]  command;
    } tick_t;

    // One result, last field in the lowest bits.
    typedef struct packed {
        logic [15:0] received_word;
        logic        done_res;
        logic        busy_res;
        logic        own_dac;
        logic        own_rfd;
        logic        own_dav;
        logic [7:0]  bus_out;
    } res_t;

    localparam int unsigned TICK_W = $bits(tick_t);
    localparam int unsigned RES_W  = $bits(res_t);

endpackage

`default_nettype wire

### hdl/parallel_handshake_transfer.sv
// Peripheral side of a byte-wide DAV/RFD/DAC parallel link with an attention line.
// Depends on pht_pkg and assert_macros.svh.
// A request is held in the input register and its result in the result register.
// Throughput: one request per cycle while the result side is not stalled; the input and result registers move together.
// Reset (rst_n low, asynchronous): idle phase, all driven lines low, words and bus byte zero.
`default_nettype none

module parallel_handshake_transfer (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // command[1:0], two_bytes[2], send_word[18:3], partner_dav[19], partner_rfd[20],
    // partner_dac[21], partner_atn[22], bus_in[30:23], zero[31]
    input  wire logic [pht_pkg::TDATA_W-1:0] s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // bus_out[7:0], own_dav[8], own_rfd[9], own_dac[10], busy_res[11], done_res[12],
    // received_word[28:13], zero[31:29]
    output logic [pht_pkg::TDATA_W-1:0]     m_tdata
);
    import pht_pkg::*;

    `include "assert_macros.svh"

    logic   in_valid_reg;
    tick_t  in_reg;
    logic   out_valid_reg;
    res_t   res_reg;
    res_t   res_next;
    logic   advance;

    phase_t      phase_reg, phase_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    lines_t      lines_reg, lines_next;
    logic [15:0] pending_reg, pending_next;
    logic [15:0] captured_reg, captured_next;
    logic        wide_reg, wide_next;
    logic        done;
    cmd_t        cmd;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign cmd      = cmd_t'(in_reg.command);

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_S_RFD:    if (in_reg.partner_rfd)  phase_next = PH_S_DAC_HI;
            PH_S_DAC_HI: if (in_reg.partner_dac)  phase_next = PH_S_DAC_LO;
            PH_S_DAC_LO: if (!in_reg.partner_dac) phase_next = PH_IDLE;
            PH_R_DAV_HI: if (in_reg.partner_dav)  phase_next = PH_R_DAV_LO;
            PH_R_DAV_LO: if (!in_reg.partner_dav) phase_next = PH_IDLE;
            PH_WAIT_ATN: if (in_reg.partner_atn)  phase_next = PH_R_DAV_HI;
            default:
            begin
                // Idle, or an unused phase code that behaves as idle.
                case (cmd)
                    CMD_SEND: phase_next = PH_S_RFD;
                    CMD_RECV: phase_next = PH_R_DAV_HI;
                    CMD_ATN:  phase_next = PH_WAIT_ATN;
                    default:  phase_next = PH_IDLE;
                endcase
            end
        endcase
    end

    // Lines, bus byte and words for each phase.
    always_comb
    begin
        out_byte_next = out_byte_reg;
        lines_next    = lines_reg;
        pending_next  = pending_reg;
        captured_next = captured_reg;
        wide_next     = wide_reg;
        done          = 1'b0;
        case (phase_reg)
            PH_S_RFD:
            begin
                if (in_reg.partner_rfd)
                begin
                    out_byte_next  = pending_reg[7:0];
                    lines_next.dav = 1'b1;
                end
            end
            PH_S_DAC_HI:
            begin
                if (in_reg.partner_dac)
                begin
                    if (wide_reg)
                    begin
                        out_byte_next = pending_reg[15:8];
                    end
                    lines_next.dav = 1'b0;
                end
            end
            PH_S_DAC_LO:
            begin
                done = !in_reg.partner_dac;
            end
            PH_R_DAV_HI:
            begin
                if (in_reg.partner_dav)
                begin
                    lines_next.rfd = 1'b0;
                    lines_next.dac = 1'b1;
                    pending_next   = {8'd0, in_reg.bus_in};
                end
            end
            PH_R_DAV_LO:
            begin
                if (!in_reg.partner_dav)
                begin
                    if (wide_reg)
                    begin
                        pending_next = {in_reg.bus_in, pending_reg[7:0]};
                    end
                    lines_next.dac = 1'b0;
                    captured_next  = pending_next;
                    done           = 1'b1;
                end
            end
            PH_WAIT_ATN:
            begin
                if (in_reg.partner_atn)
                begin
                    lines_next.rfd = 1'b1;
                end
            end
            default:
            begin
                case (cmd)
                    CMD_SEND:
                    begin
                        pending_next = in_reg.send_word;
                        wide_next    = in_reg.two_bytes;
                    end
                    CMD_RECV:
                    begin
                        wide_next      = in_reg.two_bytes;
                        lines_next.rfd = 1'b1;
                    end
                    CMD_ATN:
                    begin
                        wide_next = 1'b0;
                    end
                    default:
                    begin
                        wide_next = wide_reg;
                    end
                endcase
            end
        endcase
    end

    always_comb
    begin
        res_next.bus_out       = out_byte_next;
        res_next.own_dav       = lines_next.dav;
        res_next.own_rfd       = lines_next.rfd;
        res_next.own_dac       = lines_next.dac;
        res_next.busy_res      = (phase_next != PH_IDLE);
        res_next.done_res      = done;
        res_next.received_word = captured_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            lines_reg     <= '0;
            out_byte_reg  <= '0;
            pending_reg   <= '0;
            captured_reg  <= '0;
            wide_reg      <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                lines_reg     <= lines_next;
                out_byte_reg  <= out_byte_next;
                pending_reg   <= pending_next;
                captured_reg  <= captured_next;
                wide_reg      <= wide_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payloads carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg <= tick_t'(s_tdata[TICK_W-1:0]);
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W - RES_W){1'b0}}, res_reg};

    `ASSERT_IMP(a_idle_lines_low, clk, rst_n,
        phase_reg == PH_IDLE, lines_reg == '0)
    `ASSERT_IMP(a_no_dav_with_rfd, clk, rst_n,
        1'b1, !(lines_reg.dav && lines_reg.rfd))
    `ASSERT_NEXT(a_send_completes, clk, rst_n,
        advance && phase_reg == PH_S_DAC_LO && !in_reg.partner_dac,
        m_tvalid && res_reg.done_res && !res_reg.busy_res)
    `ASSERT_NEXT(a_request_taken, clk, rst_n,
        s_tvalid && s_tready, in_valid_reg)

endmodule

`default_nettype wire

### tb/link_monitor.sv
// Scoreboard for parallel_handshake_transfer: predicts every result from the accepted request
// and compares it field by field with what the block returns.
// Depends on pht_pkg for the request and result layouts and the phase codes.
module link_monitor (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [pht_pkg::TDATA_W-1:0] s_tdata,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [pht_pkg::TDATA_W-1:0] m_tdata,
    output int                          errors,
    output int                          pending,
    output int                          sends_done,
    output int                          recvs_done
);
    import pht_pkg::*;

    // Predicted state of the peripheral side of the link.
    phase_t      link_phase;
    logic [7:0]  drive_byte;
    lines_t      drive_lines;
    logic [15:0] word_buf;
    logic [15:0] rx_word;
    logic        wide;

    res_t        expected_q[$];

    // Advances the link by one sampled tick and returns the result it then gives: lines, bus byte, status and word.
    task automatic step_link(input tick_t t, output res_t r);
        logic fin;
        fin = 1'b0;
        case (link_phase)
            PH_S_RFD:
                if (t.partner_rfd)
                begin
                    drive_byte      = word_buf[7:0];
                    drive_lines.dav = 1'b1;
                    link_phase      = PH_S_DAC_HI;
                end
            PH_S_DAC_HI:
                if (t.partner_dac)
                begin
                    if (wide)
                        drive_byte = word_buf[15:8];
                    drive_lines.dav = 1'b0;
                    link_phase      = PH_S_DAC_LO;
                end
            PH_S_DAC_LO:
                if (!t.partner_dac)
                begin
                    link_phase = PH_IDLE;
                    fin        = 1'b1;
                    sends_done++;
                end
            PH_R_DAV_HI:
                if (t.partner_dav)
                begin
                    drive_lines.rfd = 1'b0;
                    drive_lines.dac = 1'b1;
                    word_buf        = {8'h00, t.bus_in};
                    link_phase      = PH_R_DAV_LO;
                end
            PH_R_DAV_LO:
                if (!t.partner_dav)
                begin
                    // The high byte is taken on the falling edge of the partner's DAV.
                    if (wide)
                        word_buf[15:8] = t.bus_in;
                    drive_lines.dac = 1'b0;
                    rx_word         = word_buf;
                    link_phase      = PH_IDLE;
                    fin             = 1'b1;
                    recvs_done++;
                end
            PH_WAIT_ATN:
                if (t.partner_atn)
                begin
                    drive_lines.rfd = 1'b1;
                    link_phase      = PH_R_DAV_HI;
                end
            default:
            begin
                link_phase = PH_IDLE;
                if (t.command == CMD_SEND)
                begin
                    word_buf   = t.send_word;
                    wide       = t.two_bytes;
                    link_phase = PH_S_RFD;
                end
                else if (t.command == CMD_RECV)
                begin
                    wide            = t.two_bytes;
                    drive_lines.rfd = 1'b1;
                    link_phase      = PH_R_DAV_HI;
                end
                else if (t.command == CMD_ATN)
                begin
                    wide       = 1'b0;
                    link_phase = PH_WAIT_ATN;
                end
            end
        endcase
        r.bus_out       = drive_byte;
        r.own_dav       = drive_lines.dav;
        r.own_rfd       = drive_lines.rfd;
        r.own_dac       = drive_lines.dac;
        r.busy_res      = (link_phase != PH_IDLE);
        r.done_res      = fin;
        r.received_word = rx_word;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t  got;
        res_t  want;
        res_t  pred;
        tick_t req;
        if (!rst_n)
        begin
            link_phase  = PH_IDLE;
            drive_byte  = 8'h00;
            drive_lines = '0;
            word_buf    = 16'h0000;
            rx_word     = 16'h0000;
            wide        = 1'b0;
            expected_q.delete();
            errors      = 0;
            pending     = 0;
            sends_done  = 0;
            recvs_done  = 0;
        end
        else
        begin
            // Results are compared before the new request is predicted, since a
            // result can never belong to a request accepted at the same edge.
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[RES_W-1:0];
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result %h arrived with nothing expected", $time, m_tdata);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.bus_out !== want.bus_out || got.own_dav !== want.own_dav
                        || got.own_rfd !== want.own_rfd || got.own_dac !== want.own_dac
                        || got.busy_res !== want.busy_res || got.done_res !== want.done_res
                        || got.received_word !== want.received_word
                        || m_tdata[TDATA_W-1:RES_W] !== '0)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%0t: mismatch, expected bus=%h dav=%b rfd=%b dac=%b busy=%b done=%b rx=%h",
                                     $time, want.bus_out, want.own_dav, want.own_rfd,
                                     want.own_dac, want.busy_res, want.done_res,
                                     want.received_word);
                            $display("%0t:           actual   bus=%h dav=%b rfd=%b dac=%b busy=%b done=%b rx=%h pad=%b",
                                     $time, got.bus_out, got.own_dav, got.own_rfd,
                                     got.own_dac, got.busy_res, got.done_res,
                                     got.received_word, m_tdata[TDATA_W-1:RES_W]);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                req = s_tdata[TICK_W-1:0];
                step_link(req, pred);
                expected_q.push_back(pred);
            end
            pending = expected_q.size();
        end
    end

endmodule

### tb/tb.sv
// Top of the parallel_handshake_transfer testbench: clock, reset, request and result
// traffic with random idling, a watchdog and the verdict.
// Depends on pht_pkg, the block itself and link_monitor.
module tb;
    import pht_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_TICKS = 400;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;

    int errors;
    int pending;
    int sends_done;
    int recvs_done;
    int ticks_sent = 0;
    int max_wait   = 0;
    int quiet      = 0;
    bit calm       = 1'b0;

    always #5 clk = ~clk;

    parallel_handshake_transfer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    link_monitor u_monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .errors     (errors),
        .pending    (pending),
        .sends_done (sends_done),
        .recvs_done (recvs_done)
    );

    function automatic tick_t rnd_tick();
        logic [31:0] bits;
        bits = $urandom;
        return bits[TICK_W-1:0];
    endfunction

    // Offers one tick after a random gap and returns at the edge where it is taken.
    // Ready is sampled at the falling edge, where every signal is settled.
    task automatic put_tick(input tick_t t);
        int gap;
        bit hit;
        gap = calm ? 0 : $urandom_range(0, 13);
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W-TICK_W){1'b0}}, t};
        do
        begin
            @(negedge clk);
            hit = s_tready;
            @(posedge clk);
        end while (!hit);
        ticks_sent++;
    endtask

    // A partner that accepts a send: RFD high, DAC high, DAC low, each after a few
    // ticks of the opposite level. Unrelated lines and the command carry noise.
    task automatic run_send(input logic [15:0] word, input logic two);
        tick_t t;
        t = rnd_tick();
        t.command   = CMD_SEND;
        t.two_bytes = two;
        t.send_word = word;
        put_tick(t);
        repeat ($urandom_range(0, max_wait))
        begin
            t = rnd_tick();
            t.partner_rfd = 1'b0;
            put_tick(t);
        end
        t = rnd_tick();
        t.partner_rfd = 1'b1;
        put_tick(t);
        repeat ($urandom_range(0, max_wait))
        begin
            t = rnd_tick();
            t.partner_dac = 1'b0;
            put_tick(t);
        end
        t = rnd_tick();
        t.partner_dac = 1'b1;
        put_tick(t);
        repeat ($urandom_range(0, max_wait))
        begin
            t = rnd_tick();
            t.partner_dac = 1'b1;
            put_tick(t);
        end
        t = rnd_tick();
        t.partner_dac = 1'b0;
        put_tick(t);
    endtask

    // A partner that sends one or two bytes, optionally announced by ATN first.
    task automatic run_recv(input bit via_atn, input logic two,
                            input logic [7:0] lo, input logic [7:0] hi);
        tick_t t;
        t = rnd_tick();
        t.command   = via_atn ? CMD_ATN : CMD_RECV;
        t.two_bytes = two;
        put_tick(t);
        if (via_atn)
        begin
            repeat ($urandom_range(0, max_wait))
            begin
                t = rnd_tick();
                t.partner_atn = 1'b0;
                put_tick(t);
            end
            t = rnd_tick();
            t.partner_atn = 1'b1;
            put_tick(t);
        end
        repeat ($urandom_range(0, max_wait))
        begin
            t = rnd_tick();
            t.partner_dav = 1'b0;
            put_tick(t);
        end
        t = rnd_tick();
        t.partner_dav = 1'b1;
        t.bus_in      = lo;
        put_tick(t);
        repeat ($urandom_range(0, max_wait))
        begin
            t = rnd_tick();
            t.partner_dav = 1'b1;
            put_tick(t);
        end
        t = rnd_tick();
        t.partner_dav = 1'b0;
        t.bus_in      = hi;
        put_tick(t);
    endtask

    // Three pairs of all-lines-high and DAV/DAC-low ticks bring the block back to
    // idle from any phase that random noise may have left it in.
    task automatic run_drain();
        tick_t t;
        repeat (3)
        begin
            t = rnd_tick();
            t.command     = CMD_NONE;
            t.partner_dav = 1'b1;
            t.partner_rfd = 1'b1;
            t.partner_dac = 1'b1;
            t.partner_atn = 1'b1;
            put_tick(t);
            t = rnd_tick();
            t.command     = CMD_NONE;
            t.partner_dav = 1'b0;
            t.partner_dac = 1'b0;
            put_tick(t);
        end
    endtask

    // Result side: a random stall before each result, sometimes none at all.
    initial
    begin
        int stall;
        bit hit;
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 13);
            repeat (stall)
            begin
                m_tready <= 1'b0;
                @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(negedge clk);
                hit = m_tvalid;
                @(posedge clk);
            end while (!hit);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT)
        begin
            $display("Timeout: no request or result moved for %0d cycles.", quiet);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        tick_t t;
        int    n_directed;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: idle ticks, extreme words and bytes, every command, and a
        // command arriving while a receive is in progress.
        put_tick('0);
        t = '1;
        t.command = CMD_NONE;
        put_tick(t);
        run_send(16'hFFFF, 1'b1);
        run_send(16'h5AA5, 1'b0);
        run_recv(1'b0, 1'b1, 8'hFF, 8'h00);
        run_recv(1'b0, 1'b0, 8'h00, 8'hFF);
        run_recv(1'b1, 1'b1, 8'hC3, 8'h3C);
        t = rnd_tick();
        t.command   = CMD_RECV;
        t.two_bytes = 1'b1;
        put_tick(t);
        t = rnd_tick();
        t.command     = CMD_SEND;
        t.partner_dav = 1'b0;
        put_tick(t);
        t = rnd_tick();
        t.command     = CMD_ATN;
        t.partner_dav = 1'b1;
        put_tick(t);
        t = rnd_tick();
        t.partner_dav = 1'b0;
        put_tick(t);
        n_directed = ticks_sent;

        // Mostly complete transfers with random content; now and then raw noise.
        max_wait = 3;
        while (ticks_sent < n_directed + RANDOM_TICKS)
        begin
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2: run_send(16'($urandom), 1'($urandom_range(0, 1)));
                3, 4, 5: run_recv(1'b0, 1'($urandom_range(0, 1)), 8'($urandom),
                                  8'($urandom));
                6, 7:    run_recv(1'b1, 1'b0, 8'($urandom), 8'($urandom));
                8:
                begin
                    repeat ($urandom_range(1, 6))
                        put_tick(rnd_tick());
                    run_drain();
                end
                default:
                    repeat ($urandom_range(1, 3))
                    begin
                        t = rnd_tick();
                        t.command = CMD_NONE;
                        put_tick(t);
                    end
            endcase
        end

        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Summary: %0d ticks driven, %0d sends and %0d receives completed.",
                 ticks_sent, sends_done, recvs_done);
        $display("Summary: %0d mismatching results, %0d still outstanding.", errors, pending);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
